// ===== sv/message_deframer_macros.svh =====
// message_deframer_macros.svh
// assertion macros shared by the deframer checker, no dependencies

`ifndef MESSAGE_DEFRAMER_MACROS_SVH
`define MESSAGE_DEFRAMER_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define MDF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// next-cycle implication, disabled while reset is high
`define MDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

// next-cycle implication that also holds through reset
`define MDF_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

// ===== sv/mdf_pkg.sv =====
// mdf_pkg.sv
// types, codes and constants of the message deframer, no dependencies
`timescale 1ns / 1ps

package mdf_pkg;

  // default width of the payload counter
  localparam int LENGTH_BITS_DEF = 24;

  // fixed field widths
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 24;
  localparam int KIND_W = 2;

  // register reset value
  localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 24'hFFFFFF;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_DATA    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BADFOOT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TOOLONG = 2'd3;

  // start marker "DMA@" and footer "CMPH"
  localparam logic [BYTE_W-1:0] MARKER_TEXT [4] = '{8'h44, 8'h4D, 8'h41, 8'h40};
  localparam logic [BYTE_W-1:0] FOOTER_TEXT [4] = '{8'h43, 8'h4D, 8'h50, 8'h48};

  // one result item
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] msg_type;
    logic [LEN_W-1:0]  msg_length;
  } result_t;

  // result request from parser to output stage
  typedef struct packed {
    logic    valid;
    result_t res;
  } res_req_t;

  // registered input byte from input stage to parser
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] rx_byte;
  } stage_t;

endpackage

// ===== sv/mdf_if.sv =====
// mdf_if.sv
// valid/ready channel interfaces for received bytes and results
// depends on mdf_pkg
`timescale 1ns / 1ps

interface mdf_byte_if import mdf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mdf_result_if import mdf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] data_byte;
  logic [BYTE_W-1:0] msg_type;
  logic [LEN_W-1:0]  msg_length;

  modport source (output valid, output kind, output data_byte, output msg_type,
                  output msg_length, input ready);
  modport sink   (input valid, input kind, input data_byte, input msg_type,
                  input msg_length, output ready);
endinterface

// ===== sv/mdf_in_stage.sv =====
// mdf_in_stage.sv
// input register holding one received byte until the parser takes it
// depends on mdf_pkg
`timescale 1ns / 1ps

module mdf_in_stage import mdf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [BYTE_W-1:0] in_byte,
  output logic              in_ready,
  input  logic              advance,
  output stage_t            stage
);

  logic              valid;
  logic [BYTE_W-1:0] data;

  // free when empty or when the held byte moves on this cycle
  assign in_ready = !valid || advance;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  // byte register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= in_byte;
    end
  end

  assign stage.valid   = valid;
  assign stage.rx_byte = data;

endmodule

// ===== sv/mdf_parser.sv =====
// mdf_parser.sv
// frame parser: marker hunt, header capture, payload count and footer check
// depends on mdf_pkg
`timescale 1ns / 1ps

module mdf_parser import mdf_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  input  stage_t           stage,
  input  logic             advance,
  output res_req_t         req
);

  typedef enum logic [2:0] {
    PH_HUNT, PH_TYPE, PH_LENGTH, PH_PAYLOAD, PH_FOOTER
  } phase_t;

  // largest length the payload counter can hold
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);

  phase_t                 phase, phase_next;
  logic [LENGTH_BITS-1:0] position, position_next;
  logic [BYTE_W-1:0]      held_type, held_type_next;
  logic [LEN_W-1:0]       held_length, held_length_next;
  logic                   footer_good, footer_good_next;
  logic [LEN_W-1:0]       max_length;

  logic                   step;
  logic                   emit;
  result_t                res;
  logic [BYTE_W-1:0]      b;
  logic [LEN_W-1:0]       len_shift;
  logic                   too_long;
  logic [LEN_W:0]         pos_inc;
  logic [1:0]             hunt_pos;
  logic                   foot_match;

  assign step = stage.valid && advance;
  assign b    = stage.rx_byte;

  // length shift-in and limit check
  assign len_shift = {held_length[LEN_W-BYTE_W-1:0], b};
  assign too_long  = (len_shift > max_length) || (len_shift > LEN_CAP);

  // payload count compare, one bit wider than the length
  assign pos_inc = (LEN_W + 1)'({1'b0, position} + 1'b1);

  assign hunt_pos   = (position > LENGTH_BITS'(3)) ? 2'd0 : position[1:0];
  assign foot_match = (b == FOOTER_TEXT[position[1:0]]);

  // next state and result
  always_comb begin
    phase_next       = phase;
    position_next    = position;
    held_type_next   = held_type;
    held_length_next = held_length;
    footer_good_next = footer_good;
    emit             = 1'b0;
    res.kind         = KIND_DATA;
    res.data_byte    = '0;
    res.msg_type     = held_type;
    res.msg_length   = held_length;
    unique case (phase)
      PH_TYPE: begin
        held_type_next   = b;
        held_length_next = '0;
        position_next    = '0;
        phase_next       = PH_LENGTH;
      end
      PH_LENGTH: begin
        held_length_next = len_shift;
        if (position[1:0] != 2'd2) begin
          position_next = position + 1'b1;
        end else begin
          position_next    = '0;
          footer_good_next = 1'b1;
          if (too_long) begin
            phase_next     = PH_HUNT;
            emit           = 1'b1;
            res.kind       = KIND_TOOLONG;
            res.msg_length = len_shift;
          end else if (len_shift == '0) begin
            phase_next = PH_FOOTER;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        emit          = 1'b1;
        res.data_byte = b;
        if (pos_inc >= {1'b0, held_length}) begin
          position_next    = '0;
          footer_good_next = 1'b1;
          phase_next       = PH_FOOTER;
        end else begin
          position_next = pos_inc[LENGTH_BITS-1:0];
        end
      end
      PH_FOOTER: begin
        if (!foot_match) begin
          footer_good_next = 1'b0;
        end
        if (position[1:0] != 2'd3) begin
          position_next = position + 1'b1;
        end else begin
          position_next = '0;
          phase_next    = PH_HUNT;
          emit          = 1'b1;
          res.kind      = (footer_good && foot_match) ? KIND_DONE : KIND_BADFOOT;
        end
      end
      default: begin
        // hunting, a mismatch may itself start a new marker
        phase_next = PH_HUNT;
        if (b == MARKER_TEXT[hunt_pos]) begin
          if (hunt_pos == 2'd3) begin
            position_next = '0;
            phase_next    = PH_TYPE;
          end else begin
            position_next = LENGTH_BITS'(hunt_pos + 3'd1);
          end
        end else if (b == MARKER_TEXT[0]) begin
          position_next = LENGTH_BITS'(1);
        end else begin
          position_next = '0;
        end
      end
    endcase
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      position    <= '0;
      held_type   <= '0;
      held_length <= '0;
      footer_good <= 1'b1;
    end else if (step) begin
      phase       <= phase_next;
      position    <= position_next;
      held_type   <= held_type_next;
      held_length <= held_length_next;
      footer_good <= footer_good_next;
    end
  end

  // length limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RST;
    end else if (cfg_wr_en) begin
      max_length <= cfg_wr_data;
    end
  end

  assign req.valid = step && emit;
  assign req.res   = res;

endmodule

// ===== sv/mdf_out_stage.sv =====
// mdf_out_stage.sv
// result register that holds one result until the receiver takes it
// depends on mdf_pkg
`timescale 1ns / 1ps

module mdf_out_stage import mdf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  res_req_t req,
  output logic     advance,
  output logic     out_valid,
  input  logic     out_ready,
  output result_t  out_res
);

  logic    valid;
  result_t data;

  // the parser may move when the register is empty or being emptied
  assign advance = !valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (req.valid) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (req.valid) begin
      data <= req.res;
    end
  end

  assign out_valid = valid;
  assign out_res   = data;

endmodule

// ===== sv/message_deframer.sv =====
// message_deframer: byte-serial deframer for "DMA@" framed messages.
// Bytes enter on rx (valid/ready, accepted when both are high). The block
// hunts for the marker "DMA@", takes a type byte and a 24-bit big-endian
// length, passes each payload byte out as a kind 0 result carrying the
// type and length, then checks the footer "CMPH" and gives one kind 1
// (complete) or kind 2 (bad footer) result. A length above max_length or
// above the payload counter gives one kind 3 result and the block goes
// back to hunting. Header, marker and padding bytes give no result.
// Results leave on res (valid/ready) with data_byte zero unless kind is 0.
// max_length is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while idle, the block itself does not enforce it.
// Throughput: one byte per clock while res is not stalled, set by the
// combinational parser step between the input and result registers.
// A byte waits in the input register, its result in the result register.
// Stall: while res is held the result register keeps its value; at most
// one more byte is taken into the input register, then rx ready drops.
// Reset (rst, synchronous): both registers empty, hunting for the marker,
// max_length back to 0xFFFFFF.
// depends on mdf_pkg, mdf_if, mdf_in_stage, mdf_parser, mdf_out_stage
`timescale 1ns / 1ps

module message_deframer import mdf_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  mdf_byte_if.sink         rx,
  mdf_result_if.source     res
);

  stage_t   stage;
  res_req_t req;
  logic     advance;
  result_t  out_res;

  // input register
  mdf_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_byte  (rx.rx_byte),
    .in_ready (rx.ready),
    .advance  (advance),
    .stage    (stage)
  );

  // parser
  mdf_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .stage       (stage),
    .advance     (advance),
    .req         (req)
  );

  // result register
  mdf_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .advance   (advance),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_res   (out_res)
  );

  assign res.kind       = out_res.kind;
  assign res.data_byte  = out_res.data_byte;
  assign res.msg_type   = out_res.msg_type;
  assign res.msg_length = out_res.msg_length;

endmodule

// ===== sv/mdf_checker.sv =====
// mdf_checker.sv
// port-level assertions on the deframer, bound to message_deframer
// depends on mdf_pkg and message_deframer_macros.svh
`timescale 1ns / 1ps
`include "message_deframer_macros.svh"

module mdf_checker import mdf_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              rx_ready,
  input logic              res_valid,
  input logic              res_ready,
  input logic [KIND_W-1:0] res_kind,
  input logic [BYTE_W-1:0] res_data_byte,
  input logic [BYTE_W-1:0] res_msg_type,
  input logic [LEN_W-1:0]  res_msg_length
);

  // a stalled result holds
  `MDF_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_kind) && $stable(res_data_byte) && $stable(res_msg_type) && $stable(res_msg_length))

  // only payload results carry a data byte
  `MDF_ASSERT_NOW(a_data_zero, clk, rst, res_valid && (res_kind != KIND_DATA), res_data_byte == '0)

  // an empty result register never blocks the input
  `MDF_ASSERT_NOW(a_rx_free, clk, rst, !res_valid, rx_ready)

  // reset leaves no result
  `MDF_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, !res_valid)

endmodule

bind message_deframer mdf_checker u_mdf_checker (
  .clk            (clk),
  .rst            (rst),
  .rx_ready       (rx.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_kind       (res.kind),
  .res_data_byte  (res.data_byte),
  .res_msg_type   (res.msg_type),
  .res_msg_length (res.msg_length)
);
